FILE: src/signed_int_to_decimal_ascii_top_defines.svh
// Assertion macros for the checker file of the integer-to-text block.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk and disabled while arst_n is low.
`define SITDA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk and disabled while arst_n is low.
`define SITDA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/sitda_pkg.sv
// Shared constants and types of the integer-to-text block.
package sitda_pkg;

	localparam int VALUE_W = 32;
	localparam int CHAR_W  = 8;
	localparam int DIGITS  = 10;
	localparam int DIGIT_W = 4;
	localparam int BCD_W   = DIGITS * DIGIT_W;
	localparam int CNT_W   = $clog2(VALUE_W);
	localparam int IDX_W   = $clog2(DIGITS);

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

	typedef struct packed {
		logic             valid;
		logic             neg;
		logic [BCD_W-1:0] bcd;
	} dab_res_t;

endpackage

FILE: src/sitda_if.sv
// Valid/ready channel interfaces for the input value and the output characters.
interface sitda_value_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [sitda_pkg::VALUE_W-1:0]   value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

interface sitda_char_if;
	logic                            valid;
	logic                            ready;
	logic [sitda_pkg::CHAR_W-1:0]    char_code;
	logic                            last;

	modport source (output valid, output char_code, output last, input ready);
	modport sink (input valid, input char_code, input last, output ready);
endinterface

FILE: src/sitda_dabble.sv
// Bit-serial binary to BCD converter (shift and add three), one bit per cycle.
module sitda_dabble (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [sitda_pkg::VALUE_W-1:0]       in_value,
	output sitda_pkg::dab_res_t                 res,
	input  logic                                res_ready
);

	localparam logic [sitda_pkg::CNT_W-1:0] CNT_LAST = sitda_pkg::CNT_W'(sitda_pkg::VALUE_W - 1);

	logic                              busy_q;
	logic                              done_q;
	logic                              neg_q;
	logic [sitda_pkg::CNT_W-1:0]       cnt_q;
	logic [sitda_pkg::VALUE_W-1:0]     mag_q;
	logic [sitda_pkg::BCD_W-1:0]       bcd_q;
	logic [sitda_pkg::BCD_W-1:0]       adj;
	logic                              accept;
	logic                              handoff;

	always_comb begin
		logic [sitda_pkg::DIGIT_W-1:0] d;
		for (int i = 0; i < sitda_pkg::DIGITS; i++) begin
			d = bcd_q[i*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W];
			adj[i*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W] = (d >= 4'd5) ? d + 4'd3 : d;
		end
	end

	assign handoff  = done_q && res_ready;
	assign in_ready = !busy_q && (!done_q || res_ready);
	assign accept   = in_valid && in_ready;

	assign res.valid = done_q;
	assign res.neg   = neg_q;
	assign res.bcd   = bcd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (handoff) begin
				done_q <= 1'b0;
			end
			if (accept) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= in_value[sitda_pkg::VALUE_W-1];
			mag_q <= in_value[sitda_pkg::VALUE_W-1] ? (~in_value + 1'b1) : in_value;
			bcd_q <= '0;
		end else if (busy_q) begin
			bcd_q <= {adj[sitda_pkg::BCD_W-2:0], mag_q[sitda_pkg::VALUE_W-1]};
			mag_q <= {mag_q[sitda_pkg::VALUE_W-2:0], 1'b0};
		end
	end

endmodule

FILE: src/sitda_emit.sv
// Character serializer: minus sign, then BCD digits from a nibble shift register.
module sitda_emit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sitda_pkg::dab_res_t           res,
	output logic                          res_ready,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sitda_pkg::CHAR_W-1:0]  out_char,
	output logic                          out_last
);

	localparam logic [sitda_pkg::IDX_W-1:0] IDX_TOP = sitda_pkg::IDX_W'(sitda_pkg::DIGITS - 1);

	logic                              busy_q;
	logic                              neg_q;
	logic                              ovalid_q;
	logic [sitda_pkg::BCD_W-1:0]       sh_q;
	logic [sitda_pkg::IDX_W-1:0]       rem_q;
	logic [sitda_pkg::CHAR_W-1:0]      char_q;
	logic                              last_q;
	logic [sitda_pkg::IDX_W-1:0]       msd;
	logic [sitda_pkg::BCD_W-1:0]       bcd_aligned;
	logic                              load;
	logic                              advance;
	logic [sitda_pkg::DIGIT_W-1:0]     top_digit;

	always_comb begin
		msd = '0;
		for (int i = 1; i < sitda_pkg::DIGITS; i++) begin
			if (res.bcd[i*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W] != '0) begin
				msd = sitda_pkg::IDX_W'(i);
			end
		end
	end

	assign bcd_aligned = res.bcd << {(IDX_TOP - msd), 2'b00};
	assign top_digit   = sh_q[sitda_pkg::BCD_W-1 -: sitda_pkg::DIGIT_W];

	assign res_ready = !busy_q;
	assign load      = res.valid && res_ready;
	assign advance   = busy_q && (!ovalid_q || out_ready);

	assign out_valid = ovalid_q;
	assign out_char  = char_q;
	assign out_last  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			neg_q    <= 1'b0;
			ovalid_q <= 1'b0;
			rem_q    <= '0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				neg_q  <= res.neg;
				rem_q  <= msd;
			end else if (advance) begin
				if (neg_q) begin
					neg_q <= 1'b0;
				end else begin
					rem_q <= rem_q - 1'b1;
					if (rem_q == '0) begin
						busy_q <= 1'b0;
					end
				end
			end
			if (advance) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sh_q <= bcd_aligned;
		end else if (advance) begin
			if (neg_q) begin
				char_q <= sitda_pkg::CHAR_MINUS;
				last_q <= 1'b0;
			end else begin
				char_q <= sitda_pkg::CHAR_ZERO + sitda_pkg::CHAR_W'(top_digit);
				last_q <= (rem_q == '0);
				sh_q   <= sh_q << sitda_pkg::DIGIT_W;
			end
		end
	end

endmodule

FILE: src/signed_int_to_decimal_ascii_top.sv
// Signed 32-bit integer to decimal ASCII text converter, top level.
//
// One word on value_ch carries a signed 32-bit integer. The block answers
// with its decimal text on char_ch, one character per word, most significant
// first: a minus sign for negative values, then the digits without leading
// zeros. The final character of each value has last set. Zero gives "0" and
// the most negative value gives "-2147483648".
// A bit-serial shift-and-add-three converter works through the value bit by
// bit, then hands the BCD digits to the serializer, which sends one character
// a cycle while the receiver keeps up. The converter takes no new value while
// it converts one, but it takes the next value while the serializer still
// sends.
// Reset clears all control state; no word is pending after it.
// When the receiver stalls, the current character holds in the output
// register, the serializer waits, and once the converter has finished its
// value, value_ch.ready stays low until the serializer takes the digits.
module signed_int_to_decimal_ascii_top (
	input  logic         clk,
	input  logic         arst_n,
	sitda_value_if.sink  value_ch,
	sitda_char_if.source char_ch
);

	sitda_pkg::dab_res_t res;
	logic                res_ready;

	sitda_dabble u_dabble (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (value_ch.valid),
		.in_ready  (value_ch.ready),
		.in_value  (value_ch.value),
		.res       (res),
		.res_ready (res_ready)
	);

	sitda_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.res_ready (res_ready),
		.out_valid (char_ch.valid),
		.out_ready (char_ch.ready),
		.out_char  (char_ch.char_code),
		.out_last  (char_ch.last)
	);

endmodule

FILE: src/sitda_checker.sv
// Port-level assertions for the integer-to-text block and their bind.
`include "signed_int_to_decimal_ascii_top_defines.svh"

module sitda_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [sitda_pkg::CHAR_W-1:0]  out_char,
	input logic                          out_last
);

	`SITDA_ASSERT_NOW(a_char_legal, out_valid, (out_char == sitda_pkg::CHAR_MINUS) || ((out_char >= sitda_pkg::CHAR_ZERO) && (out_char <= sitda_pkg::CHAR_ZERO + 8'd9)), "Character is neither a digit nor a minus sign.")
	`SITDA_ASSERT_NOW(a_minus_not_last, out_valid && (out_char == sitda_pkg::CHAR_MINUS), !out_last, "Minus sign flagged as the last character.")
	`SITDA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "Input ready right after a value was accepted.")
	`SITDA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_char) && $stable(out_last), "Stalled character changed.")

endmodule

bind signed_int_to_decimal_ascii_top sitda_checker u_sitda_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (value_ch.valid),
	.in_ready  (value_ch.ready),
	.out_valid (char_ch.valid),
	.out_ready (char_ch.ready),
	.out_char  (char_ch.char_code),
	.out_last  (char_ch.last)
);
